// ----- rtl/pfr_pkg.sv -----
// Package for the Pareto front ranking block: transfer types, sizes and the
// dominance test used by the lanes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

    // Fixed sizes of the objective fields.
    localparam int MAX_OBJECTIVES  = 4;
    localparam int OBJECTIVE_BITS  = 16;
    localparam int OBJ_VEC_W       = MAX_OBJECTIVES * OBJECTIVE_BITS;
    localparam int FIELD_W         = 16;
    localparam int RESULT_FIELD_W  = 6;
    localparam int NOBJ_W          = 3;

    // Defaults for the top-level parameters.
    localparam int MAX_SOLUTIONS_DEF = 64;
    localparam int LANES_DEF         = 8;

    // Configuration register indexes and reset values.
    localparam logic CFG_NUM_OBJECTIVES    = 1'b0;
    localparam logic CFG_SMALLER_IS_FITTER = 1'b1;
    localparam logic [NOBJ_W-1:0] NOBJ_RESET = 3'd2;

    typedef logic [OBJ_VEC_W-1:0] obj_vec_t;

    typedef struct packed {
        logic [FIELD_W-1:0] objective_a;
        logic [FIELD_W-1:0] objective_b;
        logic [FIELD_W-1:0] objective_c;
        logic [FIELD_W-1:0] objective_d;
        logic               last_solution;
    } item_t;

    typedef struct packed {
        logic [RESULT_FIELD_W-1:0] solution_index;
        logic [RESULT_FIELD_W-1:0] front_rank;
        logic                      last_result;
    } result_t;

    // What one lane found for its stored solution against the new one.
    typedef struct packed {
        logic old_dom_new;
        logic new_dom_old;
    } lane_res_t;

    // True when vector a strictly dominates vector b over the active objectives.
    function automatic logic dominates(
        input obj_vec_t          a,
        input obj_vec_t          b,
        input logic [NOBJ_W-1:0] nact,
        input logic              smaller
    );
        logic                      better;
        logic                      worse;
        logic [OBJECTIVE_BITS-1:0] va;
        logic [OBJECTIVE_BITS-1:0] vb;
        better = 1'b0;
        worse  = 1'b0;
        for (int k = 0; k < MAX_OBJECTIVES; k++) begin
            va = a[k*OBJECTIVE_BITS +: OBJECTIVE_BITS];
            vb = b[k*OBJECTIVE_BITS +: OBJECTIVE_BITS];
            if ((NOBJ_W'(k) < nact) && (va != vb)) begin
                if ((smaller && (va < vb)) || (!smaller && (va > vb))) begin
                    better = 1'b1;
                end
                else begin
                    worse = 1'b1;
                end
            end
        end
        return better && !worse;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pfr_lane.sv -----
// One comparison lane: holds every LANES-th solution's objectives and dominance
// row in local memories and compares them with the solution being loaded.
// Depends on pfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfr_lane
    import pfr_pkg::*;
#(
    parameter int MAX_SOLUTIONS = MAX_SOLUTIONS_DEF,
    parameter int GRP_W         = 3
)
(
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [GRP_W-1:0]         rd_addr,
    input  wire logic                     cmp_en,
    input  wire logic                     active,
    input  wire obj_vec_t                 new_obj,
    input  wire logic [$clog2(MAX_SOLUTIONS)-1:0] new_pos,
    input  wire logic [NOBJ_W-1:0]        nact,
    input  wire logic                     smaller,
    input  wire logic                     fill_en,
    input  wire logic [GRP_W-1:0]         fill_addr,
    input  wire obj_vec_t                 fill_obj,
    input  wire logic [MAX_SOLUTIONS-1:0] fill_row,
    output lane_res_t                     res,
    output logic [MAX_SOLUTIONS-1:0]      row
);

    localparam int DEPTH = 2 ** GRP_W;

    obj_vec_t                 obj_mem [DEPTH];
    logic [MAX_SOLUTIONS-1:0] row_mem [DEPTH];

    obj_vec_t                 obj_reg;
    logic [MAX_SOLUTIONS-1:0] row_reg;
    logic [GRP_W-1:0]         addr_reg;
    logic [MAX_SOLUTIONS-1:0] row_upd;
    logic                     odn;
    logic                     ndo;

    // Dominance in both directions for the stored solution just read.
    always_comb
    begin
        odn = dominates(obj_reg, new_obj, nact, smaller);
        ndo = dominates(new_obj, obj_reg, nact, smaller);
        res.old_dom_new = active && odn;
        res.new_dom_old = active && ndo && !odn;
        row_upd = row_reg;
        row_upd[new_pos] = odn;
    end

    assign row = row_reg;

    // Memory read with registered data, and the write port shared by the
    // row update during a load and the fill of a new solution.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            obj_reg  <= obj_mem[rd_addr];
            row_reg  <= row_mem[rd_addr];
            addr_reg <= rd_addr;
        end
        if (fill_en)
        begin
            obj_mem[fill_addr] <= fill_obj;
            row_mem[fill_addr] <= fill_row;
        end
        else if (cmp_en && active)
        begin
            row_mem[addr_reg] <= row_upd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pfr_merge.sv -----
// Merging stage: counts how many lanes' solutions dominate the new one, gathers
// the lanes that it dominates, and picks one lane's row for ranking.
// Depends on pfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfr_merge
    import pfr_pkg::*;
#(
    parameter int MAX_SOLUTIONS = MAX_SOLUTIONS_DEF,
    parameter int LANES         = LANES_DEF
)
(
    input  wire lane_res_t [LANES-1:0]                    res,
    input  wire logic [LANES-1:0][MAX_SOLUTIONS-1:0]      rows,
    input  wire logic [$clog2(LANES)-1:0]                 sel,
    output logic [$clog2(LANES):0]                        dom_cnt,
    output logic [LANES-1:0]                              dom_mask,
    output logic [MAX_SOLUTIONS-1:0]                      sel_row
);

    localparam int SUM_W = $clog2(LANES) + 1;

    // Population count of the old-dominates-new flags, and the new-dominates-old mask.
    always_comb
    begin
        dom_cnt = '0;
        for (int l = 0; l < LANES; l++) begin
            dom_cnt = dom_cnt + SUM_W'(res[l].old_dom_new);
            dom_mask[l] = res[l].new_dom_old;
        end
    end

    assign sel_row = rows[sel];

endmodule

`default_nettype wire

// ----- rtl/pareto_front_ranking.sv -----
// Pareto front ranking by fast non-dominated sort. Solutions are loaded one per
// transfer; LANES comparison lanes check the new solution against the stored
// ones a group at a time, each group with a read and then a compare, before the
// new solution is filled in. The item flagged last starts ranking, during which
// no item is taken: each front is formed, the indexes are scanned in order up to
// its last member, and each member's row is read and its result emitted, paced
// by the result stall. Results come out front by front in load order. Items
// beyond MAX_SOLUTIONS are dropped. LANES is a power of two, at least two, and
// MAX_SOLUTIONS is at least twice LANES.
`timescale 1ns / 1ps
`default_nettype none

module pareto_front_ranking
    import pfr_pkg::*;
#(
    parameter int MAX_SOLUTIONS = MAX_SOLUTIONS_DEF,
    parameter int LANES         = LANES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire item_t             item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [NOBJ_W-1:0] cfg_data
);

    localparam int IW     = $clog2(MAX_SOLUTIONS);
    localparam int CW     = IW + 1;
    localparam int LANE_W = $clog2(LANES);
    localparam int GRP_W  = IW - LANE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_LREAD, S_LCMP, S_LFIN, S_RFRONT, S_RSCAN, S_REMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            loaded_reg, loaded_next;
    logic [GRP_W-1:0]         grp_reg, grp_next;
    obj_vec_t                 new_obj_reg, new_obj_next;
    logic                     last_reg, last_next;
    logic [MAX_SOLUTIONS-1:0] acc_row_reg, acc_row_next;
    logic [CW-1:0]            acc_cnt_reg, acc_cnt_next;
    logic [CW-1:0]            cnt_reg [MAX_SOLUTIONS];
    logic [CW-1:0]            cnt_next [MAX_SOLUTIONS];
    logic [MAX_SOLUTIONS-1:0] assigned_reg, assigned_next;
    logic [MAX_SOLUTIONS-1:0] front_reg, front_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [RESULT_FIELD_W-1:0] rank_reg, rank_next;
    logic [CW-1:0]            emitted_reg, emitted_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_data_reg, out_data_next;
    logic [NOBJ_W-1:0]        nobj_reg, nobj_next;
    logic                     smaller_reg, smaller_next;

    logic [NOBJ_W-1:0]        nact;
    logic [MAX_SOLUTIONS-1:0] all_mask;
    logic [MAX_SOLUTIONS-1:0] free_mask;
    logic [MAX_SOLUTIONS-1:0] front_left;
    logic [CW-1:0]            next_base;
    logic                     slot_free;

    logic                     rd_en;
    logic [GRP_W-1:0]         rd_addr;
    logic                     cmp_en;
    logic [LANES-1:0]         lane_active;
    logic [LANES-1:0]         fill_en;
    lane_res_t [LANES-1:0]    lane_res;
    logic [LANES-1:0][MAX_SOLUTIONS-1:0] lane_rows;
    logic [LANE_W:0]          dom_cnt;
    logic [LANES-1:0]         dom_mask;
    logic [MAX_SOLUTIONS-1:0] sel_row;
    obj_vec_t                 item_obj;

    // Active objective count, held to the legal range.
    always_comb
    begin
        if (nobj_reg < NOBJ_W'(2))
        begin
            nact = NOBJ_W'(2);
        end
        else if (nobj_reg > NOBJ_W'(MAX_OBJECTIVES))
        begin
            nact = NOBJ_W'(MAX_OBJECTIVES);
        end
        else
        begin
            nact = nobj_reg;
        end
    end

    assign item_obj = {item.objective_d[OBJECTIVE_BITS-1:0],
                       item.objective_c[OBJECTIVE_BITS-1:0],
                       item.objective_b[OBJECTIVE_BITS-1:0],
                       item.objective_a[OBJECTIVE_BITS-1:0]};

    // Lane control.
    assign rd_en   = (state_reg == S_LREAD) ||
                     ((state_reg == S_RSCAN) && front_reg[idx_reg]);
    assign rd_addr = (state_reg == S_LREAD) ? grp_reg : idx_reg[IW-1:LANE_W];
    assign cmp_en  = (state_reg == S_LCMP);
    assign next_base = CW'({1'b0, grp_reg} + 1'b1) << LANE_W;
    assign slot_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        for (int l = 0; l < LANES; l++) begin
            lane_active[l] = cmp_en && (CW'({grp_reg, LANE_W'(l)}) < loaded_reg);
            fill_en[l] = (state_reg == S_LFIN) &&
                         (loaded_reg[LANE_W-1:0] == LANE_W'(l));
        end
        for (int j = 0; j < MAX_SOLUTIONS; j++) begin
            all_mask[j]  = CW'(j) < loaded_reg;
            free_mask[j] = all_mask[j] && !assigned_reg[j] && (cnt_reg[j] == '0);
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            pfr_lane #(
                .MAX_SOLUTIONS (MAX_SOLUTIONS),
                .GRP_W         (GRP_W)
            ) u_lane (
                .clk       (clk),
                .rd_en     (rd_en),
                .rd_addr   (rd_addr),
                .cmp_en    (cmp_en),
                .active    (lane_active[g]),
                .new_obj   (new_obj_reg),
                .new_pos   (loaded_reg[IW-1:0]),
                .nact      (nact),
                .smaller   (smaller_reg),
                .fill_en   (fill_en[g]),
                .fill_addr (loaded_reg[IW-1:LANE_W]),
                .fill_obj  (new_obj_reg),
                .fill_row  (acc_row_reg),
                .res       (lane_res[g]),
                .row       (lane_rows[g])
            );
        end
    endgenerate

    pfr_merge #(
        .MAX_SOLUTIONS (MAX_SOLUTIONS),
        .LANES         (LANES)
    ) u_merge (
        .res      (lane_res),
        .rows     (lane_rows),
        .sel      (idx_reg[LANE_W-1:0]),
        .dom_cnt  (dom_cnt),
        .dom_mask (dom_mask),
        .sel_row  (sel_row)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Next-state logic for loading and ranking.
    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        grp_next       = grp_reg;
        new_obj_next   = new_obj_reg;
        last_next      = last_reg;
        acc_row_next   = acc_row_reg;
        acc_cnt_next   = acc_cnt_reg;
        cnt_next       = cnt_reg;
        assigned_next  = assigned_reg;
        front_next     = front_reg;
        idx_next       = idx_reg;
        rank_next      = rank_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        nobj_next      = nobj_reg;
        smaller_next   = smaller_reg;
        front_left     = front_reg & ~(MAX_SOLUTIONS'(1) << idx_reg);

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_OBJECTIVES:    nobj_next = cfg_data;
                CFG_SMALLER_IS_FITTER: smaller_next = cfg_data[0];
                default:               nobj_next = nobj_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (loaded_reg == CW'(MAX_SOLUTIONS))
                    begin
                        // Overflow: the item is dropped but may start ranking.
                        if (item.last_solution)
                        begin
                            state_next = S_RFRONT;
                        end
                    end
                    else
                    begin
                        new_obj_next = item_obj;
                        last_next    = item.last_solution;
                        grp_next     = '0;
                        acc_row_next = '0;
                        acc_cnt_next = '0;
                        state_next   = (loaded_reg == '0) ? S_LFIN : S_LREAD;
                    end
                end
            end
            S_LREAD:
            begin
                state_next = S_LCMP;
            end
            S_LCMP:
            begin
                acc_cnt_next = acc_cnt_reg + CW'(dom_cnt);
                for (int l = 0; l < LANES; l++) begin
                    if (dom_mask[l])
                    begin
                        acc_row_next[{grp_reg, LANE_W'(l)}] = 1'b1;
                        cnt_next[{grp_reg, LANE_W'(l)}] =
                            cnt_reg[{grp_reg, LANE_W'(l)}] + 1'b1;
                    end
                end
                if (next_base >= loaded_reg)
                begin
                    state_next = S_LFIN;
                end
                else
                begin
                    grp_next   = grp_reg + 1'b1;
                    state_next = S_LREAD;
                end
            end
            S_LFIN:
            begin
                cnt_next[loaded_reg[IW-1:0]] = acc_cnt_reg;
                loaded_next = loaded_reg + 1'b1;
                state_next  = last_reg ? S_RFRONT : S_IDLE;
            end
            S_RFRONT:
            begin
                // Free solutions form the front; a dominance cycle takes all left.
                front_next = (free_mask != '0) ? free_mask : (all_mask & ~assigned_reg);
                idx_next   = '0;
                state_next = S_RSCAN;
            end
            S_RSCAN:
            begin
                if (front_reg[idx_reg])
                begin
                    state_next = S_REMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_REMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.solution_index = RESULT_FIELD_W'(idx_reg);
                    out_data_next.front_rank     = rank_reg;
                    out_data_next.last_result    = (emitted_reg == loaded_reg - 1'b1);
                    for (int j = 0; j < MAX_SOLUTIONS; j++) begin
                        if (sel_row[j] && (cnt_reg[j] != '0))
                        begin
                            cnt_next[j] = cnt_reg[j] - 1'b1;
                        end
                    end
                    assigned_next = assigned_reg | (MAX_SOLUTIONS'(1) << idx_reg);
                    front_next    = front_left;
                    emitted_next  = emitted_reg + 1'b1;
                    if (emitted_reg == loaded_reg - 1'b1)
                    begin
                        // Population done: clear for the next one.
                        for (int j = 0; j < MAX_SOLUTIONS; j++) begin
                            cnt_next[j] = '0;
                        end
                        loaded_next   = '0;
                        assigned_next = '0;
                        emitted_next  = '0;
                        rank_next     = '0;
                        state_next    = S_IDLE;
                    end
                    else if (front_left == '0)
                    begin
                        rank_next  = rank_reg + 1'b1;
                        state_next = S_RFRONT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RSCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            assigned_reg  <= '0;
            rank_reg      <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
            nobj_reg      <= NOBJ_RESET;
            smaller_reg   <= 1'b1;
            for (int j = 0; j < MAX_SOLUTIONS; j++) begin
                cnt_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            assigned_reg  <= assigned_next;
            rank_reg      <= rank_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
            nobj_reg      <= nobj_next;
            smaller_reg   <= smaller_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        grp_reg      <= grp_next;
        new_obj_reg  <= new_obj_next;
        last_reg     <= last_next;
        acc_row_reg  <= acc_row_next;
        acc_cnt_reg  <= acc_cnt_next;
        front_reg    <= front_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
